@@ rtl/nuscan_pkg.sv @@
// Shared types and constants of the NAL unit start code scanner.
package nuscan_pkg;

  // Width of the byte position counter; positions wrap modulo 2**POS_BITS.
  localparam int POS_BITS   = 32;
  localparam int INDEX_BITS = 32;
  localparam int OUT_BITS   = 32;

  // Event queue between front and back.
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_IDLE = 8'hFF;

  localparam logic [2:0] PREFIX_SHORT = 3'd3;
  localparam logic [2:0] PREFIX_LONG  = 3'd4;

  // One unit record, length included.
  typedef struct packed {
    logic [POS_BITS-1:0]   start;
    logic [2:0]            prefix;
    logic [5:0]            utype;
    logic [INDEX_BITS-1:0] index;
    logic [POS_BITS-1:0]   length;
  } rec_t;

  // Everything one byte causes: a closed unit, a final unit, or both.
  typedef struct packed {
    logic has_a;
    logic has_b;
    rec_t a;
    rec_t b;
  } event_t;

  // Queue status seen by the back part.
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

@@ rtl/nuscan_front.sv @@
// Front part: byte window, start code match and open unit tracking.
module nuscan_front import nuscan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output logic       ev_write,
  output event_t     ev
);

  logic [POS_BITS-1:0]   pos;
  logic [7:0]            win [4];
  logic [3:0]            scan;
  logic                  open_valid;
  rec_t                  open_rec;
  logic [INDEX_BITS-1:0] counter;

  logic                  match4;
  logic                  match3;
  logic                  match;
  logic [7:0]            header;
  logic [POS_BITS-1:0]   start_here;
  logic [POS_BITS-1:0]   pos_inc;
  logic                  open_valid_next;
  rec_t                  open_next;
  logic [INDEX_BITS-1:0] counter_next;

  always_comb begin
    match4 = scan[0] && win[0] == BYTE_ZERO && win[1] == BYTE_ZERO &&
             win[2] == BYTE_ZERO && win[3] == BYTE_ONE;
    match3 = scan[0] && !match4 && win[0] == BYTE_ZERO &&
             win[1] == BYTE_ZERO && win[2] == BYTE_ONE;
    match  = match4 || match3;
    header = match4 ? data_byte : win[3];
    start_here = pos - POS_BITS'(4);
    pos_inc    = pos + POS_BITS'(1);

    open_valid_next = open_valid;
    open_next       = open_rec;
    counter_next    = counter;
    if (match) begin
      open_valid_next  = 1'b1;
      open_next.start  = start_here;
      open_next.prefix = match4 ? PREFIX_LONG : PREFIX_SHORT;
      open_next.utype  = header[6:1];
      open_next.index  = counter;
      open_next.length = '0;
      counter_next     = counter + INDEX_BITS'(1);
    end

    ev.has_a    = match && open_valid;
    ev.a        = open_rec;
    ev.a.length = start_here - open_rec.start;
    ev.has_b    = end_of_stream && open_valid_next;
    ev.b        = open_next;
    ev.b.length = pos_inc - open_next.start;
    ev_write    = accept && (ev.has_a || ev.has_b);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_stream)) begin
      pos        <= '0;
      win        <= '{BYTE_IDLE, BYTE_IDLE, BYTE_IDLE, BYTE_IDLE};
      scan       <= '0;
      open_valid <= 1'b0;
      counter    <= '0;
    end else if (accept) begin
      pos        <= pos_inc;
      win        <= '{win[1], win[2], win[3], data_byte};
      scan[0]    <= scan[1] && !match;
      scan[1]    <= scan[2] && !match;
      scan[2]    <= scan[3] && !match;
      scan[3]    <= !match4;
      open_valid <= open_valid_next;
      counter    <= counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      open_rec <= open_next;
    end
  end

endmodule

@@ rtl/nuscan_queue.sv @@
// Short event queue between front and back.
module nuscan_queue import nuscan_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   write,
  input  event_t wdata,
  input  logic   read,
  output event_t rdata,
  output qstat_t stat
);

  event_t               mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_write;
  logic                 do_read;

  assign stat.empty = count == '0;
  assign stat.full  = count == QCNT_BITS'(QDEPTH);
  assign do_write   = write && !stat.full;
  assign do_read    = read && !stat.empty;
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_write) wptr <= wptr + QPTR_BITS'(1);
      if (do_read) rptr <= rptr + QPTR_BITS'(1);
      case ({do_write, do_read})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/nuscan_back.sv @@
// Back part: splits each queued event into one or two result records.
module nuscan_back import nuscan_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  event_t              head,
  input  qstat_t              stat,
  output logic                q_read,
  input  logic                pop,
  output logic                empty,
  output logic [OUT_BITS-1:0] unit_start,
  output logic [2:0]          prefix_len,
  output logic [5:0]          unit_type,
  output logic [OUT_BITS-1:0] unit_length,
  output logic [OUT_BITS-1:0] unit_index,
  output logic                final_unit,
  output logic                run_last
);

  // second: the closed record of the head event has gone, the final one waits
  logic second;
  logic show_b;
  rec_t cur;
  logic take;

  always_comb begin
    show_b      = second || !head.has_a;
    cur         = show_b ? head.b : head.a;
    empty       = stat.empty;
    unit_start  = OUT_BITS'(cur.start);
    prefix_len  = cur.prefix;
    unit_type   = cur.utype;
    unit_length = OUT_BITS'(cur.length);
    unit_index  = OUT_BITS'(cur.index);
    final_unit  = show_b;
    run_last    = show_b || !head.has_b;
    take        = pop && !stat.empty;
    q_read      = take && run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !run_last;
    end
  end

endmodule

@@ rtl/nal_unit_start_code_scanner_top.sv @@
// Top level of the NAL unit start code scanner.
// Scans an Annex B byte stream, one byte per transaction, for the start codes
// 00 00 00 01 and 00 00 01 and gives one record per NAL unit: start position,
// prefix length, H.265 type and length, plus its ordinal in the stream. A
// record appears once the unit's length is known, i.e. when the next start
// code has been seen (four bytes after that code's first byte) or when the
// byte flagged end_of_stream is taken; that flag also returns all state to
// the start of a new stream. A byte causes up to two records, the closed
// unit first and then the final one; run_last marks the last of them. The
// front part takes one byte every cycle while full is low: the window compare
// and the counter updates are done in the cycle of the push. Records go through a
// four-entry event queue to the back part, which delivers one record per
// pop; an event holding two records therefore needs two pops. full rises
// only while the event queue is full, so a byte is refused only when the
// result side has fallen four events behind.
module nal_unit_start_code_scanner_top import nuscan_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                end_of_stream,
  input  logic                pop,
  output logic                empty,
  output logic [OUT_BITS-1:0] unit_start,
  output logic [2:0]          prefix_len,
  output logic [5:0]          unit_type,
  output logic [OUT_BITS-1:0] unit_length,
  output logic [OUT_BITS-1:0] unit_index,
  output logic                final_unit,
  output logic                run_last
);

  logic   accept;
  logic   ev_write;
  event_t ev;
  event_t head;
  qstat_t stat;
  logic   q_read;

  assign full   = stat.full;
  assign accept = push && !stat.full;

  nuscan_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .ev_write      (ev_write),
    .ev            (ev)
  );

  nuscan_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .write (ev_write),
    .wdata (ev),
    .read  (q_read),
    .rdata (head),
    .stat  (stat)
  );

  nuscan_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (stat),
    .q_read      (q_read),
    .pop         (pop),
    .empty       (empty),
    .unit_start  (unit_start),
    .prefix_len  (prefix_len),
    .unit_type   (unit_type),
    .unit_length (unit_length),
    .unit_index  (unit_index),
    .final_unit  (final_unit),
    .run_last    (run_last)
  );

  // A final record always closes the run of its byte.
  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && final_unit) |-> run_last)
    else $error("final record not marked as last of its run");

  // Every record shown carries a legal prefix length.
  a_prefix_len: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (prefix_len == PREFIX_SHORT || prefix_len == PREFIX_LONG))
    else $error("record with bad prefix length");

  // A refused byte never enters the queue.
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !ev_write)
    else $error("event written while queue full");

  // After reset nothing waits on the result side.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> empty)
    else $error("results pending after reset");

endmodule
